// ----- hdl/fsf_pkg.sv -----
// Shared types and constants of the fire stencil filter.
package fsf_pkg;

	// Frame geometry
	localparam int FRAME_WIDTH  = 80;
	localparam int FRAME_HEIGHT = 102;
	localparam int COL_W        = $clog2(FRAME_WIDTH);
	localparam int ROW_W        = $clog2(FRAME_HEIGHT);
	localparam int SEED_ROW     = FRAME_HEIGHT - 2;

	// Seed generator
	localparam logic [15:0] LFSR_INIT = 16'hACE1;

	// Register file reset values
	localparam logic [7:0] DECAY_RST     = 8'd2;
	localparam logic [7:0] SEED_BASE_RST = 8'hC0;
	localparam logic [7:0] RAND_MASK_RST = 8'h3F;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_DECAY     = 2'd0,
		REG_SEED_BASE = 2'd1,
		REG_RAND_MASK = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] heat_in;
		logic       frame_start;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] heat_out;
		logic [6:0] out_row;
		logic [6:0] out_col;
		logic       seed_valid;
		logic [7:0] seed_heat;
		logic       frame_last;
	} out_beat_t;

endpackage

// ----- hdl/fire_stencil_filter_top.sv -----
// Top level of the fire stencil filter: row store, window, seeding and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | in_data  (heat_in, frame_start)
//   out     | output    | out_valid / out_ready| out_data (heat_out, position, seed)
//   apb     | input     | psel / penable       | paddr, pwdata, prdata (3 registers)
//
// One pixel per clock unless the output stalls; results pass stage 1 and out_q.
// The row store is a one-port-write, one-port-read memory read one column ahead.
// Reset clears counters, window and seed generator; the row store is not cleared.
// in_ready drops only while a result is held in the stage and the output beat stalls.
module fire_stencil_filter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  fsf_pkg::in_beat_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output fsf_pkg::out_beat_t                out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fsf_pkg::PADDR_W-1:0]       paddr,
	input  logic [fsf_pkg::PDATA_W-1:0]       pwdata,
	output logic [fsf_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import fsf_pkg::*;

	// Registers
	logic [7:0] decay_q, seed_base_q, rand_mask_q;
	logic       cfg_wr;
	reg_idx_t   cfg_idx;

	// Position and seed state
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      lfsr_q;
	logic [7:0]       first_q;

	// Accept-side signals
	logic             in_fire;
	logic [COL_W-1:0] cur_col, nxt_col, rd_addr;
	logic [ROW_W-1:0] cur_row, nxt_row;
	logic [COL_W:0]   col_inc;
	logic             col_last, row_last, seeded;
	logic             lfsr_fb;
	logic [15:0]      lfsr_step;
	logic [7:0]       seed, pix;

	// Row store
	logic [7:0] row_mem [FRAME_WIDTH];

	// Stage 1
	logic             valid_s1, has_res_s1, seeded_s1, last_s1, col_first_s1, col_end_s1;
	logic [7:0]       pix_s1, seed_s1, first_s1, rd_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             s1_move;

	// Window and result
	logic [7:0]       win_left_q, win_center_q;
	logic [7:0]       left_w, center_w, right_w;
	logic [9:0]       sum_w;
	logic [7:0]       avg_w, heat_w;
	logic [ROW_W-1:0] row_m2;
	logic             out_valid_q;
	out_beat_t        out_q;

	// Configuration writes and reads
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q     <= DECAY_RST;
			seed_base_q <= SEED_BASE_RST;
			rand_mask_q <= RAND_MASK_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DECAY:     decay_q     <= pwdata[7:0];
				REG_SEED_BASE: seed_base_q <= pwdata[7:0];
				REG_RAND_MASK: rand_mask_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DECAY:     prdata = {24'd0, decay_q};
			REG_SEED_BASE: prdata = {24'd0, seed_base_q};
			REG_RAND_MASK: prdata = {24'd0, rand_mask_q};
			default:       prdata = '0;
		endcase
	end

	// Position of the incoming pixel, seed replacement and next position
	assign in_fire   = in_valid && in_ready;
	assign cur_col   = in_data.frame_start ? '0 : col_q;
	assign cur_row   = in_data.frame_start ? '0 : row_q;
	assign col_inc   = {1'b0, cur_col} + (COL_W+1)'(1);
	assign col_last  = (cur_col == COL_W'(FRAME_WIDTH - 1));
	assign row_last  = (cur_row == ROW_W'(FRAME_HEIGHT - 1));
	assign seeded    = (cur_row >= ROW_W'(SEED_ROW));
	assign lfsr_fb   = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign lfsr_step = {lfsr_fb, lfsr_q[15:1]};
	assign seed      = (lfsr_step[7:0] & rand_mask_q) | seed_base_q;
	assign pix       = seeded ? seed : in_data.heat_in;
	assign rd_addr   = col_last ? '0 : col_inc[COL_W-1:0];
	assign nxt_col   = col_last ? '0 : col_inc[COL_W-1:0];
	assign nxt_row   = col_last ? (row_last ? '0 : cur_row + ROW_W'(1)) : cur_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lfsr_q <= LFSR_INIT;
		end else if (in_fire) begin
			col_q <= nxt_col;
			row_q <= nxt_row;
			if (seeded) begin
				lfsr_q <= lfsr_step;
			end
		end
	end

	// Write the current pixel, read the right neighbor from the row above
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_mem[cur_col] <= pix;
			rd_s1            <= row_mem[rd_addr];
		end
	end

	// Keep a copy of column zero so the row start needs no second read port
	always_ff @(posedge clk) begin
		if (in_fire && cur_col == '0) begin
			first_q <= pix;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1       <= pix;
			seed_s1      <= seeded ? seed : 8'd0;
			seeded_s1    <= seeded;
			first_s1     <= first_q;
			col_s1       <= cur_col;
			row_s1       <= cur_row;
			has_res_s1   <= (cur_row >= ROW_W'(2));
			last_s1      <= row_last && col_last;
			col_first_s1 <= (cur_col == '0);
			col_end_s1   <= col_last;
		end
	end

	// Advance stage 1 when its result has room or it carries none
	assign s1_move  = valid_s1 && (!has_res_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stencil: average of four, minus decay, floored at zero
	assign left_w   = col_first_s1 ? first_s1 : win_left_q;
	assign center_w = col_first_s1 ? first_s1 : win_center_q;
	assign right_w  = col_end_s1 ? center_w : rd_s1;
	assign sum_w    = 10'(left_w) + 10'(center_w) + 10'(right_w) + 10'(pix_s1);
	assign avg_w    = sum_w[9:2];
	assign heat_w   = (avg_w > decay_q) ? (avg_w - decay_q) : 8'd0;
	assign row_m2   = row_s1 - ROW_W'(2);

	// Slide the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_center_q <= '0;
		end else if (s1_move) begin
			win_left_q   <= center_w;
			win_center_q <= right_w;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && has_res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && has_res_s1) begin
			out_q.heat_out   <= heat_w;
			out_q.out_row    <= 7'(row_m2);
			out_q.out_col    <= 7'(col_s1);
			out_q.seed_valid <= seeded_s1;
			out_q.seed_heat  <= seed_s1;
			out_q.frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/fsf_checker.sv -----
// Port-level checks of the fire stencil filter and their binding to the top level.
module fsf_props (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  fsf_pkg::out_beat_t          out_data
);
	import fsf_pkg::*;

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Seed heat is zero outside the seed rows
	a_seed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.seed_valid |-> out_data.seed_heat == 8'd0)
		else $error("seed heat set on a non-seed pixel");

	// The last result of a frame sits at the bottom-right output position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |->
			out_data.out_col == 7'(FRAME_WIDTH - 1) &&
			out_data.out_row == 7'(FRAME_HEIGHT - 3) && out_data.seed_valid)
		else $error("frame end flagged at the wrong position");

	// No result appears without an accepted pixel before it
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a pixel behind it");

endmodule

bind fire_stencil_filter_top fsf_props u_fsf_props (.*);
